/* hw/rtl/midi_poly_voice_channel_splitter_unit_assert.svh */
// Assertion macros used by the voice splitter datapath.
`ifndef MIDI_POLY_VOICE_CHANNEL_SPLITTER_UNIT_ASSERT_SVH
`define MIDI_POLY_VOICE_CHANNEL_SPLITTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MPVCS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voice splitter check failed");

// Next-cycle implication, disabled during reset.
`define MPVCS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voice splitter check failed");

`endif

/* hw/rtl/mpvcs_pkg.sv */
// Types and constants of the MIDI polyphonic voice splitter.
package mpvcs_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHANNEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_MASK = 2'd2;

  localparam logic [3:0] RST_FIRST_CHANNEL  = 4'd1;
  localparam logic [3:0] RST_OUT_CHANNELS   = 4'd7;
  localparam logic [3:0] RST_BROADCAST_MASK = 4'd15;

  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_KEY_AT   = 4'hA;
  localparam logic [3:0] MSG_CC       = 4'hB;
  localparam logic [3:0] MSG_PROGRAM  = 4'hC;
  localparam logic [3:0] MSG_CHAN_AT  = 4'hD;
  localparam logic [3:0] MSG_PITCH    = 4'hE;

  localparam int BCAST_BIT_CC      = 0;
  localparam int BCAST_BIT_PROGRAM = 1;
  localparam int BCAST_BIT_PITCH   = 2;
  localparam int BCAST_BIT_CHAN_AT = 3;

  localparam logic [1:0] DISP_PASS    = 2'd0;
  localparam logic [1:0] DISP_REWRITE = 2'd1;
  localparam logic [1:0] DISP_DROP    = 2'd2;
  localparam logic [1:0] DISP_COPY    = 2'd3;

  localparam logic [7:0] AGE_HELD  = 8'hFF;
  // released slot after the aging step of its own note-off
  localparam logic [7:0] AGE_FRESH = 8'hFD;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FINISH = 4'b0100,
    ST_COPY   = 4'b1000
  } state_t;

  typedef struct packed {
    logic start;
    logic scan_step;
    logic idx_clear;
    logic commit;
    logic copy_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_bcast;
    logic idx_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/mpvcs_ctrl.sv */
// Controller state machine of the voice splitter.
module mpvcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mpvcs_pkg::dp_stat_t stat,
  output mpvcs_pkg::ctrl_cmd_t cmd
);

  mpvcs_pkg::state_t state;
  mpvcs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpvcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      mpvcs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = mpvcs_pkg::ST_SCAN;
        end
      end
      mpvcs_pkg::ST_SCAN: begin
        if (stat.is_bcast) begin
          cmd.idx_clear = 1'b1;
          state_next    = mpvcs_pkg::ST_COPY;
        end else begin
          cmd.scan_step = 1'b1;
          if (stat.idx_last) begin
            state_next = mpvcs_pkg::ST_FINISH;
          end
        end
      end
      mpvcs_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = mpvcs_pkg::ST_IDLE;
        end
      end
      mpvcs_pkg::ST_COPY: begin
        if (stat.out_free) begin
          cmd.copy_load = 1'b1;
          if (stat.idx_last) begin
            state_next = mpvcs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = mpvcs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/mpvcs_dp.sv */
// Datapath of the voice splitter: registers, slot table, scan and result register.
`include "midi_poly_voice_channel_splitter_unit_assert.svh"

module mpvcs_dp #(
  parameter int NUM_SLOTS = 9
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mpvcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mpvcs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [7:0]                          status_byte,
  input  logic [6:0]                          data_one,
  input  logic [6:0]                          data_two,
  input  logic                                out_ready,
  input  mpvcs_pkg::ctrl_cmd_t                cmd,
  output mpvcs_pkg::dp_stat_t                 stat,
  output logic                                out_valid,
  output logic [7:0]                          out_status,
  output logic [6:0]                          out_data_one,
  output logic [6:0]                          out_data_two,
  output logic [1:0]                          disposition,
  output logic                                last_result
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [CW-1:0] NUM_SLOTS_C = CW'(NUM_SLOTS);

  logic [3:0] first_channel;
  logic [3:0] out_channels;
  logic [3:0] broadcast_mask;

  logic [7:0] slot_age [NUM_SLOTS];
  logic [6:0] slot_key [NUM_SLOTS];
  logic [3:0] latest_channel;
  logic       latest_valid;

  logic [7:0] msg_status;
  logic [6:0] msg_d1;
  logic [6:0] msg_d2;

  logic [SW-1:0] idx;
  logic          held_found;
  logic [SW-1:0] held_idx;
  logic          same_found;
  logic [SW-1:0] same_idx;
  logic          best_found;
  logic [SW-1:0] best_idx;
  logic [7:0]    best_age;

  logic [CW-1:0] n_use;
  logic [3:0]    msg_type;
  logic          bcast_bit;
  logic [7:0]    cur_age;
  logic [6:0]    cur_key;
  logic          pick_found;
  logic [SW-1:0] pick_idx;
  logic [7:0]    res_status;
  logic [6:0]    res_d1;
  logic [6:0]    res_d2;
  logic [1:0]    res_disp;

  function automatic logic [3:0] chan_of(input logic [SW-1:0] s, input logic [3:0] base);
    return 4'(s) + base;
  endfunction

  always_comb begin
    if (out_channels == 4'd0) begin
      n_use = CW'(1);
    end else if (int'(out_channels) > NUM_SLOTS) begin
      n_use = NUM_SLOTS_C;
    end else begin
      n_use = CW'(out_channels);
    end
  end

  assign msg_type   = msg_status[7:4];
  assign cur_age    = slot_age[idx];
  assign cur_key    = slot_key[idx];
  assign pick_found = same_found || best_found;
  assign pick_idx   = same_found ? same_idx : best_idx;

  always_comb begin
    case (msg_type)
      mpvcs_pkg::MSG_CC:      bcast_bit = broadcast_mask[mpvcs_pkg::BCAST_BIT_CC];
      mpvcs_pkg::MSG_PROGRAM: bcast_bit = broadcast_mask[mpvcs_pkg::BCAST_BIT_PROGRAM];
      mpvcs_pkg::MSG_PITCH:   bcast_bit = broadcast_mask[mpvcs_pkg::BCAST_BIT_PITCH];
      mpvcs_pkg::MSG_CHAN_AT: bcast_bit = broadcast_mask[mpvcs_pkg::BCAST_BIT_CHAN_AT];
      default:                bcast_bit = 1'b0;
    endcase
  end

  assign stat.is_bcast = bcast_bit;
  assign stat.idx_last = (CW'(idx) == n_use - CW'(1));
  assign stat.out_free = !out_valid || out_ready;

  always_comb begin
    res_status = msg_status;
    res_d1     = msg_d1;
    res_d2     = msg_d2;
    res_disp   = mpvcs_pkg::DISP_DROP;
    case (msg_type)
      mpvcs_pkg::MSG_NOTE_ON: begin
        if (pick_found) begin
          res_status = {msg_type, chan_of(pick_idx, first_channel)};
          res_disp   = mpvcs_pkg::DISP_REWRITE;
        end
      end
      mpvcs_pkg::MSG_NOTE_OFF: begin
        if (held_found) begin
          res_status = {msg_type, chan_of(held_idx, first_channel)};
          res_disp   = mpvcs_pkg::DISP_REWRITE;
        end
      end
      mpvcs_pkg::MSG_KEY_AT: begin
        if (held_found) begin
          res_status = {mpvcs_pkg::MSG_CHAN_AT, chan_of(held_idx, first_channel)};
          res_d1     = msg_d2;
          res_d2     = 7'd0;
          res_disp   = mpvcs_pkg::DISP_REWRITE;
        end
      end
      mpvcs_pkg::MSG_CC, mpvcs_pkg::MSG_PROGRAM, mpvcs_pkg::MSG_PITCH,
      mpvcs_pkg::MSG_CHAN_AT: begin
        if (latest_valid) begin
          res_status = {msg_type, latest_channel};
          res_disp   = mpvcs_pkg::DISP_REWRITE;
        end
      end
      default: begin
        res_disp = mpvcs_pkg::DISP_PASS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_channel  <= mpvcs_pkg::RST_FIRST_CHANNEL;
      out_channels   <= mpvcs_pkg::RST_OUT_CHANNELS;
      broadcast_mask <= mpvcs_pkg::RST_BROADCAST_MASK;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_age[i] <= 8'd0;
        slot_key[i] <= 7'd0;
      end
      latest_channel <= 4'd0;
      latest_valid   <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          mpvcs_pkg::CFG_FIRST_CHANNEL:  first_channel  <= cfg_data;
          mpvcs_pkg::CFG_OUT_CHANNELS:   out_channels   <= cfg_data;
          mpvcs_pkg::CFG_BROADCAST_MASK: broadcast_mask <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit && msg_type == mpvcs_pkg::MSG_NOTE_ON && pick_found) begin
        slot_key[pick_idx] <= msg_d1;
        slot_age[pick_idx] <= mpvcs_pkg::AGE_HELD;
        latest_channel     <= chan_of(pick_idx, first_channel);
        latest_valid       <= 1'b1;
      end
      if (cmd.commit && msg_type == mpvcs_pkg::MSG_NOTE_OFF && held_found) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (i < int'(n_use)) begin
            if (SW'(i) == held_idx) begin
              slot_age[i] <= mpvcs_pkg::AGE_FRESH;
            end else if (slot_age[i] != mpvcs_pkg::AGE_HELD && slot_age[i] != 8'd0) begin
              slot_age[i] <= slot_age[i] - 8'd1;
            end
          end
        end
      end
      if (cmd.commit || cmd.copy_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      msg_status <= status_byte;
      msg_d1     <= data_one;
      msg_d2     <= data_two;
      idx        <= '0;
      held_found <= 1'b0;
      same_found <= 1'b0;
      best_found <= 1'b0;
      best_age   <= mpvcs_pkg::AGE_HELD;
    end
    if (cmd.scan_step) begin
      idx <= idx + SW'(1);
      if (cur_age == mpvcs_pkg::AGE_HELD && cur_key == msg_d1 && !held_found) begin
        held_found <= 1'b1;
        held_idx   <= idx;
      end
      if (cur_age != mpvcs_pkg::AGE_HELD && cur_key == msg_d1 && !same_found) begin
        same_found <= 1'b1;
        same_idx   <= idx;
      end
      if (cur_age < best_age) begin
        best_found <= 1'b1;
        best_idx   <= idx;
        best_age   <= cur_age;
      end
    end
    if (cmd.idx_clear) begin
      idx <= '0;
    end
    if (cmd.copy_load) begin
      idx          <= idx + SW'(1);
      out_status   <= {msg_type, chan_of(idx, first_channel)};
      out_data_one <= msg_d1;
      out_data_two <= msg_d2;
      disposition  <= mpvcs_pkg::DISP_COPY;
      last_result  <= stat.idx_last;
    end
    if (cmd.commit) begin
      out_status   <= res_status;
      out_data_one <= res_d1;
      out_data_two <= res_d2;
      disposition  <= res_disp;
      last_result  <= 1'b1;
    end
  end

  `MPVCS_ASSERT_IMP(a_commit_slot_free, cmd.commit, stat.out_free)
  `MPVCS_ASSERT_IMP(a_copy_slot_free, cmd.copy_load, stat.out_free)
  `MPVCS_ASSERT_NXT(a_note_on_marks_latest, cmd.commit && msg_type == mpvcs_pkg::MSG_NOTE_ON && pick_found, latest_valid)

endmodule

/* hw/rtl/midi_poly_voice_channel_splitter_unit.sv */
// Top level of the MIDI polyphonic voice splitter.
//
//   channel  signals                                         handshake
//   in       status_byte data_one data_two                   in_valid / in_ready
//   out      out_status out_data_one out_data_two            out_valid / out_ready
//            disposition last_result
//   cfg      cfg_index cfg_data                              cfg_write, no wait
//
// A message is accepted, then the slot table is scanned at one slot per cycle over
// the slots in use, then the result is loaded once the output register is free.
// A broadcast is accepted, then sends one copy per cycle while out_ready is high.
// The serial slot scan sets the rate. Synchronous reset clears all slots.
// A result waits in the output register while out_ready is low; the scan still runs.
module midi_poly_voice_channel_splitter_unit #(
  parameter int NUM_SLOTS = 9
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mpvcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpvcs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       status_byte,
  input  logic [6:0]                       data_one,
  input  logic [6:0]                       data_two,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_status,
  output logic [6:0]                       out_data_one,
  output logic [6:0]                       out_data_two,
  output logic [1:0]                       disposition,
  output logic                             last_result
);

  mpvcs_pkg::ctrl_cmd_t cmd;
  mpvcs_pkg::dp_stat_t  stat;

  mpvcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mpvcs_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .status_byte  (status_byte),
    .data_one     (data_one),
    .data_two     (data_two),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_data_one (out_data_one),
    .out_data_two (out_data_two),
    .disposition  (disposition),
    .last_result  (last_result)
  );

endmodule
